// ===== rtl/chained_hash_table_engine_assert.svh =====
// Assertion macros for the chained hash table engine.
// The including module must provide signals named clk and rst.
`ifndef CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cht_pkg.sv =====
// Shared types and constants for the chained hash table engine.
// No dependencies; used by every module of the block but cht_ram.
`default_nettype none

package cht_pkg;

  localparam int BUCKETS = 64;   // power of two: the bucket is the low key bits
  localparam int POOL    = 48;

  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int WALK_W   = $clog2(BUCKETS + 1);
  localparam int ENT_AW   = $clog2(POOL);
  localparam int IDX_W    = $clog2(POOL + 1);
  localparam int COUNT_W  = 6;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int FUNC_W   = 3;

  localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL);

  localparam logic [FUNC_W-1:0] FUNC_PUT    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FIRST  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_NEXT   = 3'd5;

  typedef enum logic [2:0] {
    OP_PUT, OP_GET, OP_REMOVE, OP_CLEAR, OP_FIRST, OP_NEXT, OP_NOP
  } op_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [KEY_W-1:0]   out_key;
    logic [VALUE_W-1:0] out_value;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [BKT_W-1:0]   bucket;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] count;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/cht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cht_front.sv =====
// Front end: decodes each request into a command and queues it in two slots.
// Depends on cht_pkg.
`default_nettype none

module cht_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire cht_pkg::req_t req,
  output      logic          q_valid,
  input  wire logic          q_pop,
  output      cht_pkg::cmd_t q_item
);

  cht_pkg::cmd_t slot [2];
  logic          wp;
  logic          rp;
  logic [1:0]    fill;
  cht_pkg::cmd_t cmd;
  logic          push;

  always_comb begin
    cmd.key    = req.key;
    cmd.value  = req.value;
    cmd.bucket = req.key[cht_pkg::BKT_W-1:0];
    case (req.func)
      cht_pkg::FUNC_PUT:    cmd.op = cht_pkg::OP_PUT;
      cht_pkg::FUNC_GET:    cmd.op = cht_pkg::OP_GET;
      cht_pkg::FUNC_REMOVE: cmd.op = cht_pkg::OP_REMOVE;
      cht_pkg::FUNC_CLEAR:  cmd.op = cht_pkg::OP_CLEAR;
      cht_pkg::FUNC_FIRST:  cmd.op = cht_pkg::OP_FIRST;
      cht_pkg::FUNC_NEXT:   cmd.op = cht_pkg::OP_NEXT;
      default:              cmd.op = cht_pkg::OP_NOP;
    endcase
  end

  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (fill != 2'd0);
  assign q_item    = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= cmd;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop && q_valid) begin
        rp <= ~rp;
      end
      case ({push, q_pop && q_valid})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cht_back.sv =====
// Back end: sequencer that walks chains and buckets through the table RAMs.
// Depends on cht_pkg and cht_ram.
`default_nettype none

module cht_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output      logic             q_pop,
  input  wire cht_pkg::cmd_t    q_item,
  output      logic             rsp_valid,
  input  wire logic             rsp_stall,
  output      cht_pkg::rsp_t    rsp,
  output      cht_pkg::status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_HEAD, S_READ, S_CMP, S_FREE, S_ALLOC, S_INSERT,
    S_WLINK, S_WALK, S_WHEAD, S_WOUT, S_DONE
  } state_t;

  state_t                        state;
  cht_pkg::op_t                  op;
  logic [cht_pkg::KEY_W-1:0]     key_q;
  logic [cht_pkg::VALUE_W-1:0]   value_q;
  logic [cht_pkg::BKT_W-1:0]     bkt_q;
  logic [cht_pkg::IDX_W-1:0]     cur;
  logic [cht_pkg::IDX_W-1:0]     prev;
  logic [cht_pkg::IDX_W-1:0]     first;
  logic [cht_pkg::IDX_W-1:0]     free_head;
  logic [cht_pkg::IDX_W-1:0]     fresh;
  logic [cht_pkg::IDX_W-1:0]     count;
  logic [cht_pkg::WALK_W-1:0]    walk_bucket;
  logic [cht_pkg::IDX_W-1:0]     walk_entry;
  logic [cht_pkg::BUCKETS-1:0]   head_valid;
  logic                          hv_q;
  logic                          res_ok;
  logic [cht_pkg::KEY_W-1:0]     res_key;
  logic [cht_pkg::VALUE_W-1:0]   res_value;

  logic                          head_re;
  logic [cht_pkg::BKT_W-1:0]     head_raddr;
  logic [cht_pkg::IDX_W-1:0]     head_rd;
  logic                          head_we;
  logic [cht_pkg::BKT_W-1:0]     head_waddr;
  logic [cht_pkg::IDX_W-1:0]     head_wdata;
  logic                          ent_re;
  logic [cht_pkg::IDX_W-1:0]     ent_raddr;
  logic [cht_pkg::KEY_W-1:0]     key_rd;
  logic [cht_pkg::VALUE_W-1:0]   value_rd;
  logic [cht_pkg::IDX_W-1:0]     link_rd;
  logic                          key_we;
  logic                          value_we;
  logic [cht_pkg::IDX_W-1:0]     kv_waddr;
  logic                          link_we;
  logic [cht_pkg::IDX_W-1:0]     link_waddr;
  logic [cht_pkg::IDX_W-1:0]     link_wdata;
  logic [cht_pkg::IDX_W-1:0]     ins_idx;
  logic [cht_pkg::IDX_W-1:0]     head_cur;
  logic                          key_hit;

  assign ins_idx  = (free_head != cht_pkg::NIL) ? free_head : fresh;
  assign head_cur = hv_q ? head_rd : cht_pkg::NIL;
  assign key_hit  = (key_rd == key_q);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign status.count = count;

  always_comb begin
    head_re    = 1'b0;
    head_raddr = bkt_q;
    head_we    = 1'b0;
    head_waddr = bkt_q;
    head_wdata = ins_idx;
    ent_re     = 1'b0;
    ent_raddr  = cur;
    key_we     = 1'b0;
    value_we   = 1'b0;
    kv_waddr   = cur;
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = free_head;
    case (state)
      S_START: begin
        if ((op == cht_pkg::OP_PUT && count != cht_pkg::NIL) ||
            op == cht_pkg::OP_GET || op == cht_pkg::OP_REMOVE) begin
          head_re = 1'b1;
        end
        if (op == cht_pkg::OP_NEXT && walk_entry != cht_pkg::NIL) begin
          ent_re    = 1'b1;
          ent_raddr = walk_entry;
        end
      end
      S_READ: begin
        ent_re = 1'b1;
      end
      S_CMP: begin
        if (key_hit && op == cht_pkg::OP_PUT) begin
          value_we = 1'b1;
        end
        if (key_hit && op == cht_pkg::OP_REMOVE) begin
          if (prev == cht_pkg::NIL) begin
            head_we    = 1'b1;
            head_wdata = link_rd;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev;
            link_wdata = link_rd;
          end
        end
      end
      S_FREE: begin
        link_we = 1'b1;
      end
      S_ALLOC: begin
        if (free_head != cht_pkg::NIL) begin
          ent_re    = 1'b1;
          ent_raddr = free_head;
        end
      end
      S_INSERT: begin
        key_we     = 1'b1;
        value_we   = 1'b1;
        kv_waddr   = ins_idx;
        link_we    = 1'b1;
        link_waddr = ins_idx;
        link_wdata = first;
        head_we    = 1'b1;
      end
      S_WALK: begin
        if (walk_entry != cht_pkg::NIL) begin
          ent_re    = 1'b1;
          ent_raddr = walk_entry;
        end else if (walk_bucket != cht_pkg::WALK_W'(cht_pkg::BUCKETS)) begin
          head_re    = 1'b1;
          head_raddr = walk_bucket[cht_pkg::BKT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  cht_ram #(.WIDTH(cht_pkg::IDX_W), .DEPTH(cht_pkg::BUCKETS)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .re(head_re), .raddr(head_raddr), .rdata(head_rd)
  );

  cht_ram #(.WIDTH(cht_pkg::KEY_W), .DEPTH(cht_pkg::POOL)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(kv_waddr[cht_pkg::ENT_AW-1:0]), .wdata(key_q),
    .re(ent_re), .raddr(ent_raddr[cht_pkg::ENT_AW-1:0]), .rdata(key_rd)
  );

  cht_ram #(.WIDTH(cht_pkg::VALUE_W), .DEPTH(cht_pkg::POOL)) u_value_ram (
    .clk(clk), .we(value_we), .waddr(kv_waddr[cht_pkg::ENT_AW-1:0]), .wdata(value_q),
    .re(ent_re), .raddr(ent_raddr[cht_pkg::ENT_AW-1:0]), .rdata(value_rd)
  );

  cht_ram #(.WIDTH(cht_pkg::IDX_W), .DEPTH(cht_pkg::POOL)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr[cht_pkg::ENT_AW-1:0]), .wdata(link_wdata),
    .re(ent_re), .raddr(ent_raddr[cht_pkg::ENT_AW-1:0]), .rdata(link_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      free_head   <= cht_pkg::NIL;
      fresh       <= '0;
      count       <= '0;
      walk_bucket <= '0;
      walk_entry  <= cht_pkg::NIL;
      head_valid  <= '0;
    end else begin
      // In S_DONE the response register is handled below.
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      if (head_re) begin
        hv_q <= head_valid[head_raddr];
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            op        <= q_item.op;
            key_q     <= q_item.key;
            value_q   <= q_item.value;
            bkt_q     <= q_item.bucket;
            res_ok    <= 1'b0;
            res_key   <= '0;
            res_value <= '0;
            state     <= S_START;
          end
        end
        S_START: begin
          case (op)
            cht_pkg::OP_PUT: begin
              state <= (count == cht_pkg::NIL) ? S_DONE : S_HEAD;
            end
            cht_pkg::OP_GET, cht_pkg::OP_REMOVE: begin
              state <= S_HEAD;
            end
            cht_pkg::OP_CLEAR: begin
              head_valid <= '0;
              free_head  <= cht_pkg::NIL;
              fresh      <= '0;
              count      <= '0;
              walk_entry <= cht_pkg::NIL;
              state      <= S_DONE;
            end
            cht_pkg::OP_FIRST: begin
              walk_bucket <= '0;
              walk_entry  <= cht_pkg::NIL;
              state       <= S_WALK;
            end
            cht_pkg::OP_NEXT: begin
              state <= (walk_entry != cht_pkg::NIL) ? S_WLINK : S_WALK;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_HEAD: begin
          cur   <= head_cur;
          first <= head_cur;
          prev  <= cht_pkg::NIL;
          if (head_cur == cht_pkg::NIL) begin
            state <= (op == cht_pkg::OP_PUT) ? S_ALLOC : S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (key_hit) begin
            res_ok <= 1'b1;
            case (op)
              cht_pkg::OP_GET: begin
                res_value <= value_rd;
                state     <= S_DONE;
              end
              cht_pkg::OP_REMOVE: begin
                if (walk_entry == cur) begin
                  walk_entry <= link_rd;
                end
                state <= S_FREE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end else begin
            prev <= cur;
            cur  <= link_rd;
            if (link_rd == cht_pkg::NIL) begin
              state <= (op == cht_pkg::OP_PUT) ? S_ALLOC : S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_FREE: begin
          free_head <= cur;
          count     <= count - 1'b1;
          state     <= S_DONE;
        end
        S_ALLOC: begin
          state <= S_INSERT;
        end
        S_INSERT: begin
          if (free_head != cht_pkg::NIL) begin
            free_head <= link_rd;
          end else begin
            fresh <= fresh + 1'b1;
          end
          count             <= count + 1'b1;
          head_valid[bkt_q] <= 1'b1;
          res_ok            <= 1'b1;
          state             <= S_DONE;
        end
        S_WLINK: begin
          walk_entry <= link_rd;
          state      <= S_WALK;
        end
        S_WALK: begin
          if (walk_entry != cht_pkg::NIL) begin
            state <= S_WOUT;
          end else if (walk_bucket == cht_pkg::WALK_W'(cht_pkg::BUCKETS)) begin
            state <= S_DONE;
          end else begin
            walk_bucket <= walk_bucket + 1'b1;
            state       <= S_WHEAD;
          end
        end
        S_WHEAD: begin
          walk_entry <= head_cur;
          state      <= S_WALK;
        end
        S_WOUT: begin
          res_ok    <= 1'b1;
          res_key   <= key_rd;
          res_value <= value_rd;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid       <= 1'b1;
            rsp.ok          <= res_ok;
            rsp.out_key     <= res_key;
            rsp.out_value   <= res_value;
            rsp.entry_count <= cht_pkg::COUNT_W'(count);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/chained_hash_table_engine.sv =====
// Chained hash table engine: one response per request, in request order. Clear, unused codes
// and a put to a full pool go straight to the response; get, put and remove read the bucket
// head and compare the chain entries one by one, then a put of a new key inserts an entry and
// a remove frees the one it unlinks. First scans the buckets from the start; next first
// follows a set cursor. The back end takes one request at a time; a two-slot queue takes
// them early. Reset (synchronous, active high) empties every bucket and the pool at once.
`default_nettype none

`include "chained_hash_table_engine_assert.svh"

module chained_hash_table_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire cht_pkg::req_t req,
  output      logic          rsp_valid,
  input  wire logic          rsp_stall,
  output      cht_pkg::rsp_t rsp
);

  // The front end decodes the function code and takes the bucket from the
  // low key bits, then parks the command in a two-slot queue. This lets a
  // new request transfer while the back end is still walking a chain.
  logic             q_valid;
  logic             q_pop;
  cht_pkg::cmd_t    q_item;
  cht_pkg::status_t status;

  cht_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // The back end owns the bucket head RAM, the entry key, value and link
  // RAMs, the free list and the iteration cursor. Entries are first handed
  // out in index order from a fill counter, and recycled entries go on the
  // free list, so no clearing pass is needed after reset or clear. Bucket
  // heads carry one valid bit each that reset and clear wipe at once.
  // Its result register holds a finished response until the transfer.
  cht_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .status    (status)
  );

  // A failed operation never returns a key or a value.
  `CHT_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp.ok, rsp.out_key == '0 && rsp.out_value == '0, "failed response carries data")

  // The stored count never exceeds the pool size.
  `CHT_ASSERT_NOW(a_count_max, 1'b1, status.count <= cht_pkg::NIL, "stored count beyond pool")

  // The count moves by at most one per cycle, except when a clear empties it.
  `CHT_ASSERT_NEXT(a_count_step, 1'b1, status.count == $past(status.count) || status.count == $past(status.count) + 1'b1 || status.count == $past(status.count) - 1'b1 || status.count == '0, "stored count jumped")

endmodule

`default_nettype wire

// ===== sim/chained_hash_table_engine_tb.sv =====
// Self-checking testbench for the chained hash table engine.
// It uses cht_pkg for the transfer types and the function codes, and it needs only the RTL.
`default_nettype none

// Scoreboard: keeps a model of the table and a queue of the responses it expects.
class hash_table_scoreboard;
  int unsigned               bucket_head [cht_pkg::BUCKETS];
  bit [31:0]                 slot_key    [cht_pkg::POOL];
  bit [31:0]                 slot_value  [cht_pkg::POOL];
  int unsigned               slot_link   [cht_pkg::POOL];
  int unsigned               free_slot;
  int unsigned               stored;
  int unsigned               scan_bucket;
  int unsigned               cursor;
  cht_pkg::rsp_t             expected_rsp [$];
  int unsigned               mismatches;

  function new();
    for (int b = 0; b < cht_pkg::BUCKETS; b++) bucket_head[b] = cht_pkg::POOL;
    for (int i = 0; i < cht_pkg::POOL; i++) begin
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_link[i]  = i + 1;
    end
    free_slot   = 0;
    stored      = 0;
    scan_bucket = 0;
    cursor      = cht_pkg::POOL;
    mismatches  = 0;
  endfunction

  function int unsigned lookup(bit [31:0] k);
    int unsigned e;
    int unsigned steps;
    e = bucket_head[k % cht_pkg::BUCKETS];
    steps = 0;
    while (e < cht_pkg::POOL && steps <= cht_pkg::POOL) begin
      if (slot_key[e] == k) return e;
      e = slot_link[e];
      steps++;
    end
    return cht_pkg::POOL;
  endfunction

  function bit store(bit [31:0] k, bit [31:0] v);
    int unsigned e;
    int unsigned b;
    if (stored >= cht_pkg::POOL) return 1'b0;
    e = lookup(k);
    if (e < cht_pkg::POOL) begin
      slot_value[e] = v;
      return 1'b1;
    end
    e = free_slot;
    if (e >= cht_pkg::POOL) return 1'b0;
    free_slot = slot_link[e];
    b = k % cht_pkg::BUCKETS;
    slot_key[e]    = k;
    slot_value[e]  = v;
    slot_link[e]   = bucket_head[b];
    bucket_head[b] = e;
    stored++;
    return 1'b1;
  endfunction

  function bit unlink(bit [31:0] k);
    int unsigned b;
    int unsigned prev;
    int unsigned e;
    int unsigned succ;
    int unsigned steps;
    b = k % cht_pkg::BUCKETS;
    prev = cht_pkg::POOL;
    e = bucket_head[b];
    steps = 0;
    while (e < cht_pkg::POOL && steps <= cht_pkg::POOL) begin
      if (slot_key[e] == k) begin
        succ = slot_link[e];
        if (prev == cht_pkg::POOL) bucket_head[b] = succ;
        else slot_link[prev] = succ;
        // A removed cursor slides to its successor in the chain.
        if (cursor == e) cursor = succ;
        slot_link[e] = free_slot;
        free_slot = e;
        if (stored > 0) stored--;
        return 1'b1;
      end
      prev = e;
      e = slot_link[e];
      steps++;
    end
    return 1'b0;
  endfunction

  function void wipe();
    int unsigned e;
    int unsigned succ;
    int unsigned steps;
    for (int b = 0; b < cht_pkg::BUCKETS; b++) begin
      e = bucket_head[b];
      steps = 0;
      while (e < cht_pkg::POOL && steps <= cht_pkg::POOL) begin
        succ = slot_link[e];
        slot_link[e] = free_slot;
        free_slot = e;
        e = succ;
        steps++;
      end
      bucket_head[b] = cht_pkg::POOL;
    end
    stored = 0;
    cursor = cht_pkg::POOL;
  endfunction

  function int unsigned advance_cursor();
    if (cursor < cht_pkg::POOL) cursor = slot_link[cursor];
    while (cursor >= cht_pkg::POOL) begin
      if (scan_bucket >= cht_pkg::BUCKETS) begin
        cursor = cht_pkg::POOL;
        return cht_pkg::POOL;
      end
      cursor = bucket_head[scan_bucket];
      scan_bucket++;
    end
    return cursor;
  endfunction

  // Called for every accepted request transfer.
  function void note_request(cht_pkg::req_t r);
    cht_pkg::rsp_t rsp;
    int unsigned e;
    rsp = '0;
    case (r.func)
      cht_pkg::FUNC_PUT: rsp.ok = store(r.key, r.value);
      cht_pkg::FUNC_GET: begin
        e = lookup(r.key);
        if (e < cht_pkg::POOL) begin
          rsp.ok = 1'b1;
          rsp.out_value = slot_value[e];
        end
      end
      cht_pkg::FUNC_REMOVE: rsp.ok = unlink(r.key);
      cht_pkg::FUNC_CLEAR: wipe();
      cht_pkg::FUNC_FIRST, cht_pkg::FUNC_NEXT: begin
        if (r.func == cht_pkg::FUNC_FIRST) begin
          scan_bucket = 0;
          cursor = cht_pkg::POOL;
        end
        e = advance_cursor();
        if (e < cht_pkg::POOL) begin
          rsp.ok = 1'b1;
          rsp.out_key = slot_key[e];
          rsp.out_value = slot_value[e];
        end
      end
      default: ;
    endcase
    rsp.entry_count = stored[5:0];
    expected_rsp.push_back(rsp);
  endfunction

  // Called for every accepted response transfer.
  function void check_response(cht_pkg::rsp_t got);
    cht_pkg::rsp_t want;
    if (expected_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected response: %p", got);
      return;
    end
    want = expected_rsp.pop_front();
    if (got.ok !== want.ok || got.out_key !== want.out_key ||
        got.out_value !== want.out_value || got.entry_count !== want.entry_count) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Response mismatch: expected ok=%0d key=%h value=%h count=%0d, got ok=%0d key=%h value=%h count=%0d",
                 want.ok, want.out_key, want.out_value, want.entry_count,
                 got.ok, got.out_key, got.out_value, got.entry_count);
    end
  endfunction
endclass

module chained_hash_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;   // cycles with no transfer before the run is abandoned
  localparam int LONG_HOLD  = 300;    // receiver hold-off used to back the block up
  localparam int ITEM_GOAL  = 750;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  cht_pkg::req_t  req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  cht_pkg::rsp_t  rsp;

  hash_table_scoreboard table_sb = new();

  // Knobs of the main sequence, some shared with the sender and the receiver.
  int unsigned hold_cycles = 0;   // nonzero asks the receiver for one long hold-off
  bit          no_idle     = 1'b0; // both sides run without gaps while set
  bit          held        = 1'b0; // the long hold-off has been requested
  bit          drained     = 1'b0; // the full pause has been done
  int unsigned sent        = 0;
  bit [31:0]   key_set [96];

  chained_hash_table_engine dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every response transfer goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) table_sb.check_response(rsp);
  end

  // The watchdog counts cycles in which neither channel completes a transfer.
  int unsigned idle_count = 0;
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // Receiver: stalls for a random number of cycles before each response unless no_idle is set, and once
  // holds off for a long stretch so that the request queue fills and stalls.
  initial begin : receiver
    int unsigned w;
    @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        w = hold_cycles;
        hold_cycles = 0;
      end else begin
        w = no_idle ? 0 : $urandom_range(0, 14);
      end
      if (w > 0) begin
        rsp_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  // Sends one request. The valid stays high from one request to the next when there
  // is no gap, so it is never lowered and raised again at the same edge.
  task automatic send_request(logic [cht_pkg::FUNC_W-1:0] f, bit [31:0] k, bit [31:0] v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{func: f, key: k, value: v};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    table_sb.note_request('{func: f, key: k, value: v});
    sent++;
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    @(posedge clk);
    while (table_sb.expected_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic bit [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return key_set[$urandom_range(0, 95)];
  endfunction

  // Random operation mix that favors puts so the chains grow and the pool fills.
  task automatic random_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 38)      send_request(cht_pkg::FUNC_PUT, pick_key(), $urandom);
    else if (r < 58) send_request(cht_pkg::FUNC_GET, pick_key(), $urandom);
    else if (r < 76) send_request(cht_pkg::FUNC_REMOVE, pick_key(), $urandom);
    else if (r < 81) send_request(cht_pkg::FUNC_FIRST, $urandom, $urandom);
    else if (r < 95) send_request(cht_pkg::FUNC_NEXT, $urandom, $urandom);
    else if (r < 97) send_request(cht_pkg::FUNC_CLEAR, $urandom, $urandom);
    else             send_request(3'($urandom_range(6, 7)), $urandom, $urandom);
  endtask

  // Fills the whole pool, checks that puts then fail, walks every entry and clears.
  task automatic fill_and_walk();
    bit [31:0] k;
    for (int i = 0; i < cht_pkg::POOL + 2; i++) begin
      k = ($urandom & ~32'h3F) | 32'(i % 8);
      send_request(cht_pkg::FUNC_PUT, k, $urandom);
    end
    send_request(cht_pkg::FUNC_PUT, k, $urandom);   // second put of the last key while full
    send_request(cht_pkg::FUNC_FIRST, 0, 0);
    for (int i = 0; i < cht_pkg::POOL + 1; i++) send_request(cht_pkg::FUNC_NEXT, 0, 0);
    send_request(cht_pkg::FUNC_CLEAR, 0, 0);
  endtask

  initial begin : main_sequence
    for (int i = 0; i < 96; i++) key_set[i] = ($urandom & ~32'h3F) | 32'($urandom_range(0, 11));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme fields, collisions in one bucket, cursor removal, clear.
    send_request(cht_pkg::FUNC_NEXT, 0, 0);                   // iteration on an empty table
    send_request(cht_pkg::FUNC_PUT, 32'h0, 32'h0);
    send_request(cht_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(cht_pkg::FUNC_GET, 32'h0, 0);
    send_request(cht_pkg::FUNC_GET, 32'hFFFF_FFFF, 0);
    send_request(cht_pkg::FUNC_GET, 32'h1234_5678, 0);        // key not present
    send_request(cht_pkg::FUNC_PUT, 32'h0, 32'hA5A5_5A5A);    // update keeps the chain
    send_request(cht_pkg::FUNC_PUT, 32'd5, 32'h1111_1111);
    send_request(cht_pkg::FUNC_PUT, 32'd69, 32'h2222_2222);   // same bucket as 5
    send_request(cht_pkg::FUNC_PUT, 32'd133, 32'h3333_3333);  // same bucket again
    send_request(cht_pkg::FUNC_FIRST, 0, 0);
    send_request(cht_pkg::FUNC_NEXT, 0, 0);                   // cursor lands in the 5 chain
    send_request(cht_pkg::FUNC_REMOVE, 32'd69, 0);            // remove the entry that follows the cursor
    send_request(cht_pkg::FUNC_NEXT, 0, 0);
    send_request(cht_pkg::FUNC_REMOVE, 32'd69, 0);            // already gone
    send_request(cht_pkg::FUNC_REMOVE, 32'd133, 0);           // head of the chain
    send_request(cht_pkg::FUNC_NEXT, 0, 0);
    send_request(cht_pkg::FUNC_CLEAR, 0, 0);
    send_request(cht_pkg::FUNC_NEXT, 0, 0);                   // scan resumes after clear
    send_request(cht_pkg::FUNC_NEXT, 0, 0);                   // past the end
    send_request(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd7, 0, 0);
    send_request(cht_pkg::FUNC_PUT, 32'h8000_0000, 32'h8000_0001);

    fill_and_walk();

    // Random part with a long receiver hold-off, a full pause, and a stretch
    // without any idling on either side.
    while (sent < ITEM_GOAL) begin
      if (sent % 150 == 0) fill_and_walk();
      if (!held && sent >= 250) begin
        held = 1'b1;
        hold_cycles = LONG_HOLD;
        no_idle = 1'b1;
        repeat (10) random_request();
        no_idle = 1'b0;
      end
      if (!drained && sent >= 420) begin
        drained = 1'b1;
        drain_responses();
      end
      no_idle = (sent >= 500 && sent < 580);
      random_request();
    end
    no_idle = 1'b0;

    drain_responses();
    repeat (200) @(posedge clk);
    if (table_sb.mismatches == 0 && table_sb.expected_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

`default_nettype wire
